// ----- sv/gcc_pkg.sv -----
// Shared types, constants and codes for the grid cell counter.
// Used by every module of the block; depends on nothing.
package gcc_pkg;

  // Default storage sizes
  localparam int CELLS_DEFAULT       = 65536;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  // Divider geometry: 32-bit dividend, 16-bit divisor, two quotient bits a cycle
  localparam int DIVIDEND_WIDTH  = 32;
  localparam int DIVISOR_WIDTH   = 16;
  localparam int BITS_PER_CYCLE  = 2;
  localparam int DIV_CYCLES      = DIVIDEND_WIDTH / BITS_PER_CYCLE;

  // Cell index arithmetic: row (17 bits) times columns (17 bits) plus column
  localparam int GRID_WIDTH  = 17;
  localparam int PROD_WIDTH  = 2 * GRID_WIDTH;
  localparam int INDEX_WIDTH = PROD_WIDTH + 1;

  // Configuration port
  localparam int DATA_WIDTH    = 32;
  localparam int ADDR_WIDTH    = 5;
  localparam int REG_IDX_WIDTH = 3;

  localparam logic [REG_IDX_WIDTH-1:0] REG_MIN_X     = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MIN_Y     = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_CELL_SIZE = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_GRID_COLS = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_GRID_ROWS = 3'd4;

  // Input mode codes
  localparam logic MODE_COUNT    = 1'b0;
  localparam logic MODE_FINALIZE = 1'b1;

  // Result outcome codes
  localparam logic [1:0] OUTCOME_OK      = 2'd0;
  localparam logic [1:0] OUTCOME_OUTSIDE = 2'd1;
  localparam logic [1:0] OUTCOME_EMPTY   = 2'd2;

  // Input word
  typedef struct packed {
    logic               mode;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [15:0] cell_index;
    logic        cell_complete;
    logic [1:0]  outcome;
  } out_word_t;

  // Configuration register contents
  typedef struct packed {
    logic signed [31:0]       min_x;
    logic signed [31:0]       min_y;
    logic [15:0]              cell_size;
    logic [GRID_WIDTH-1:0]    grid_cols;
    logic [GRID_WIDTH-1:0]    grid_rows;
  } cfg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_RANGE,
    ST_INDEX,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic load;
    logic take_col;
    logic take_row;
    logic range_step;
    logic index_step;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ----- sv/gcc_regs.sv -----
// APB-style configuration registers of the grid cell counter.
// Depends on gcc_pkg for the register map and the cfg_t struct.
module gcc_regs
  import gcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                     wr_en;
  logic [REG_IDX_WIDTH-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_WIDTH-1:2];

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_x     <= '0;
      cfg.min_y     <= '0;
      cfg.cell_size <= 16'd1;
      cfg.grid_cols <= 17'd1;
      cfg.grid_rows <= 17'd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_X:     cfg.min_x     <= pwdata;
        REG_MIN_Y:     cfg.min_y     <= pwdata;
        REG_CELL_SIZE: cfg.cell_size <= pwdata[15:0];
        REG_GRID_COLS: cfg.grid_cols <= pwdata[GRID_WIDTH-1:0];
        REG_GRID_ROWS: cfg.grid_rows <= pwdata[GRID_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_MIN_X:     prdata = cfg.min_x;
      REG_MIN_Y:     prdata = cfg.min_y;
      REG_CELL_SIZE: prdata = DATA_WIDTH'(cfg.cell_size);
      REG_GRID_COLS: prdata = DATA_WIDTH'(cfg.grid_cols);
      REG_GRID_ROWS: prdata = DATA_WIDTH'(cfg.grid_rows);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- sv/gcc_div.sv -----
// Restoring unsigned divider, 32-bit dividend by 16-bit divisor, two bits a cycle.
// Depends on gcc_pkg for the divider geometry.
module gcc_div
  import gcc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DIVIDEND_WIDTH-1:0] dividend,
  input  logic [DIVISOR_WIDTH-1:0]  divisor,
  output logic                      done,
  output logic [DIVIDEND_WIDTH-1:0] quotient
);

  localparam int CNT_WIDTH = $clog2(DIV_CYCLES);
  localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DIV_CYCLES - 1);

  logic                      busy;
  logic [CNT_WIDTH-1:0]      cnt;
  logic [DIVISOR_WIDTH-1:0]  rem;
  logic [DIVIDEND_WIDTH-1:0] quo;
  logic [DIVISOR_WIDTH-1:0]  rem_next;
  logic [DIVIDEND_WIDTH-1:0] quo_next;
  logic [DIVISOR_WIDTH:0]    trial;
  logic [DIVISOR_WIDTH-1:0]  r;
  logic [DIVIDEND_WIDTH-1:0] q;

  assign quotient = quo;

  // Shift in dividend bits and subtract the divisor where it fits
  always_comb begin
    r     = rem;
    q     = quo;
    trial = '0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial = {r, q[DIVIDEND_WIDTH-1]};
      q     = {q[DIVIDEND_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
        q[0]  = 1'b1;
      end
      r = trial[DIVISOR_WIDTH-1:0];
    end
    rem_next = r;
    quo_next = q;
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

// ----- sv/gcc_dp.sv -----
// Datapath: offsets, shared divider, index arithmetic, counter memory, result register.
// Depends on gcc_pkg and gcc_div.
module gcc_dp
  import gcc_pkg::*;
#(
  parameter int CELLS       = CELLS_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [AW-1:0]          CLR_LAST  = AW'(CELLS - 1);
  localparam logic [INDEX_WIDTH-1:0] IDX_LIMIT = INDEX_WIDTH'(CELLS);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE   = COUNT_WIDTH'(1);

  logic [COUNT_WIDTH-1:0] mem [CELLS];

  logic signed [32:0]        dx_comb;
  logic signed [32:0]        dy_comb;
  logic [DIVISOR_WIDTH-1:0]  size;
  logic                      div_start;
  logic [DIVIDEND_WIDTH-1:0] div_dividend;
  logic                      div_done;
  logic [DIVIDEND_WIDTH-1:0] div_quotient;

  logic                      mode;
  logic                      neg_x;
  logic                      neg_y;
  logic [DIVIDEND_WIDTH-1:0] dy;
  logic [DIVIDEND_WIDTH-1:0] col;
  logic [DIVIDEND_WIDTH-1:0] qy;
  logic                      outside;
  logic [PROD_WIDTH-1:0]     prod;
  logic [INDEX_WIDTH-1:0]    idx;
  logic [GRID_WIDTH-1:0]     row;
  logic [AW-1:0]             clr_cnt;
  logic [COUNT_WIDTH-1:0]    rd_data;

  logic                      outside_all;
  logic                      upd_write;
  logic [COUNT_WIDTH-1:0]    upd_data;
  out_word_t                 upd_word;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [COUNT_WIDTH-1:0]    wr_data;

  // Offsets of the point from the origin, 33 bits signed
  assign dx_comb = 33'(in_word.x_coord) - 33'(cfg.min_x);
  assign dy_comb = 33'(in_word.y_coord) - 33'(cfg.min_y);

  // Zero cell size acts as one
  assign size = (cfg.cell_size == '0) ? DIVISOR_WIDTH'(1) : cfg.cell_size;

  // Divide x on load, y once the column is taken
  assign div_start    = cmd.load || cmd.take_col;
  assign div_dividend = cmd.load ? dx_comb[DIVIDEND_WIDTH-1:0] : dy;

  gcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (size),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Latch the word and offsets
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode  <= in_word.mode;
      neg_x <= dx_comb[32];
      neg_y <= dy_comb[32];
      dy    <= dy_comb[DIVIDEND_WIDTH-1:0];
    end
  end

  // Capture quotients
  always_ff @(posedge clk) begin
    if (cmd.take_col) begin
      col <= div_quotient;
    end
    if (cmd.take_row) begin
      qy <= div_quotient;
    end
  end

  // Row counted from the top; only meaningful when qy is inside the grid
  assign row = cfg.grid_rows - GRID_WIDTH'(1) - qy[GRID_WIDTH-1:0];

  // Range check and row product, then add the column
  always_ff @(posedge clk) begin
    if (cmd.range_step) begin
      outside <= neg_x || neg_y
              || (col >= DIVIDEND_WIDTH'(cfg.grid_cols))
              || (qy >= DIVIDEND_WIDTH'(cfg.grid_rows));
      prod    <= row * cfg.grid_cols;
    end
    if (cmd.index_step) begin
      idx <= INDEX_WIDTH'(prod) + INDEX_WIDTH'(col[GRID_WIDTH-1:0]);
    end
  end

  // Step the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Compute the counter update and the result word
  always_comb begin
    outside_all = outside || (idx >= IDX_LIMIT);
    upd_write   = 1'b0;
    upd_data    = rd_data;
    upd_word.cell_index    = idx[15:0];
    upd_word.cell_complete = 1'b0;
    upd_word.outcome       = OUTCOME_OK;
    if (outside_all) begin
      upd_word.cell_index = '0;
      upd_word.outcome    = OUTCOME_OUTSIDE;
    end else if (mode == MODE_COUNT) begin
      if (rd_data != CNT_MAX) begin
        upd_data  = rd_data + CNT_ONE;
        upd_write = 1'b1;
      end
    end else if (rd_data != '0) begin
      upd_data  = rd_data - CNT_ONE;
      upd_write = 1'b1;
      upd_word.cell_complete = (rd_data == CNT_ONE);
    end else begin
      upd_word.outcome = OUTCOME_EMPTY;
    end
  end

  assign wr_en   = cmd.clear_step || (cmd.finish && upd_write);
  assign wr_addr = cmd.clear_step ? clr_cnt : idx[AW-1:0];
  assign wr_data = cmd.clear_step ? '0 : upd_data;

  // Counter memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word <= upd_word;
    end
  end

  assign status.clear_last = (clr_cnt == CLR_LAST);
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || !out_stall;

endmodule

// ----- sv/gcc_ctrl.sv -----
// Controller: sequences clearing, division, index arithmetic and counter update.
// Depends on gcc_pkg for state_t, cmd_t and status_t.
module gcc_ctrl
  import gcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_DIV_X;
      ST_DIV_X:  if (status.div_done) state_next = ST_DIV_Y;
      ST_DIV_Y:  if (status.div_done) state_next = ST_RANGE;
      ST_RANGE:  state_next = ST_INDEX;
      ST_INDEX:  state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV_X:  cmd.take_col   = status.div_done;
      ST_DIV_Y:  cmd.take_row   = status.div_done;
      ST_RANGE:  cmd.range_step = 1'b1;
      ST_INDEX:  cmd.index_step = 1'b1;
      ST_READ:   ;
      ST_UPDATE: cmd.finish     = status.out_free;
      default:   ;
    endcase
  end

endmodule

// ----- sv/grid_cell_count_and_finalize_top.sv -----
// Top level of the grid cell counter with finalize pass.
// Depends on gcc_pkg, gcc_regs, gcc_ctrl and gcc_dp.
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_stall   in_word_t  (mode, x_coord, y_coord)
//   out      output     out_valid / out_stall out_word_t (cell_index, cell_complete, outcome)
//   cfg      input      APB psel/penable      pwrite, paddr, pwdata -> prdata, pready
//
// The next word is accepted only once the last is through: the column and row quotients on the
// shared two-bit-a-cycle divider, then range check with row product, index add, memory read
// and read-modify-write of the counter.
// After reset a clearing pass zeroes the counter memory, one entry a cycle, with in_stall high;
// configuration writes are taken throughout.
// A result waits in the output register while out_stall is high; the word in progress
// holds in its last step until that register frees up.
module grid_cell_count_and_finalize_top
  import gcc_pkg::*;
#(
  parameter int CELLS       = CELLS_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  gcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gcc_dp #(
    .CELLS       (CELLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Block stays busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while previous one still in progress");

  // No word taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> in_stall)
    else $error("input accepted during memory clear");

  // Finish only into a free output register
  a_finish_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending word");

  // A new result appears only after a finish
  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("out_valid rose without a finish");

endmodule
